FILE: design/vsfp_pkg.sv
package vsfp_pkg;

    // Frame geometry (byte offsets within the datagram)
    localparam int unsigned IDX_W = 6;
    localparam logic [IDX_W-1:0] OFS_STREAM   = 6'd4;
    localparam logic [IDX_W-1:0] OFS_DEST     = 6'd6;
    localparam logic [IDX_W-1:0] OFS_SOURCE   = 6'd12;
    localparam logic [IDX_W-1:0] OFS_KIND     = 6'd18;
    localparam logic [IDX_W-1:0] OFS_KIND_END = 6'd20;
    localparam logic [IDX_W-1:0] OFS_FNUM     = 6'd34;
    localparam logic [IDX_W-1:0] OFS_PAYLOAD0 = 6'd36;
    localparam logic [IDX_W-1:0] OFS_PAYLOAD1 = 6'd44;
    localparam logic [IDX_W-1:0] CRC_BYTES    = 6'd52;
    localparam logic [IDX_W-1:0] FRAME_BYTES  = 6'd54;
    localparam logic [IDX_W-1:0] LAST_BYTE    = FRAME_BYTES - 6'd1;

    localparam logic [15:0] CRC_SEED       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_RESET = 16'h5935;
    localparam logic [1:0]  VOICE_BITS     = 2'b10;

    typedef struct packed {
        logic [15:0] stream_id;
        logic [47:0] dest_code;
        logic [47:0] source_code;
        logic [15:0] frame_kind;
        logic [15:0] frame_number;
        logic        crc_match;
        logic [63:0] payload0;
        logic [63:0] payload1;
    } t_frame;

    typedef struct packed {
        logic frame_done; // request completes a full frame
        logic near_end;   // next request may complete a frame
    } t_cap_status;

    // One byte of CRC-16, MSB first, top bit of the generator implicit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ poly;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

FILE: design/vsfp_byte_if.sv
interface vsfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source(output valid, output data_byte, output end_of_datagram, input ready);
    modport sink(input valid, input data_byte, input end_of_datagram, output ready);
endinterface

FILE: design/vsfp_result_if.sv
interface vsfp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] stream_id;
    logic [47:0] dest_code;
    logic [47:0] source_code;
    logic [15:0] frame_kind;
    logic [15:0] frame_number;
    logic        voice_only;
    logic        crc_match;
    logic [63:0] payload_half;
    logic        last_half;

    modport source(output valid, output stream_id, output dest_code, output source_code,
                   output frame_kind, output frame_number, output voice_only,
                   output crc_match, output payload_half, output last_half,
                   input ready);
    modport sink(input valid, input stream_id, input dest_code, input source_code,
                 input frame_kind, input frame_number, input voice_only,
                 input crc_match, input payload_half, input last_half,
                 output ready);
endinterface

FILE: design/voice_stream_frame_parser_unit.sv
// Results of a frame appear in the cycle after the request carrying its end mark.
// One byte request per cycle while the input is not stalled; a frame yields two results, first half then second.
// Input stalls only when a byte at offset 53 or later arrives while the previous
// frame's results are still waiting in the output register.
// Reset (synchronous, active low): byte count cleared, CRC to 0xFFFF, polynomial to
// 0x5935, output empty. Captured header and payload bytes are not reset.
module voice_stream_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_crc_wr_en,
    input  logic [15:0] i_crc_wr_data,
    vsfp_byte_if.sink   i_byte,
    vsfp_result_if.source o_result
);

    // CRC generator; the user must write it only while idle, the block itself does not enforce this
    logic [15:0] r_poly;

    // Output snapshot: holds a whole frame so the capture path can run ahead
    vsfp_pkg::t_frame r_frame;
    logic [1:0]       r_left, n_left;   // results still to hand over

    vsfp_pkg::t_frame      cap_frame;
    vsfp_pkg::t_cap_status cap_stat;
    logic                  take;
    logic                  busy;
    logic                  out_take;

    assign busy     = (r_left != 2'd0);
    // hold off only the byte that could complete another frame
    assign i_byte.ready = !(busy && cap_stat.near_end);
    assign take     = i_byte.valid && i_byte.ready;
    assign out_take = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= vsfp_pkg::CRC_POLY_RESET;
        end else if (i_crc_wr_en) begin
            r_poly <= i_crc_wr_data;
        end
    end

    vsfp_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_byte.data_byte),
        .i_end   (i_byte.end_of_datagram),
        .i_poly  (r_poly),
        .o_frame (cap_frame),
        .o_stat  (cap_stat)
    );

    // frame_done can only fire when the snapshot is empty, so load and unload never clash
    always_comb begin
        n_left = r_left;
        if (cap_stat.frame_done) begin
            n_left = 2'd2;
        end else if (out_take) begin
            n_left = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap_stat.frame_done) begin
            r_frame <= cap_frame;
        end
    end

    assign o_result.valid        = busy;
    assign o_result.stream_id    = r_frame.stream_id;
    assign o_result.dest_code    = r_frame.dest_code;
    assign o_result.source_code  = r_frame.source_code;
    assign o_result.frame_kind   = r_frame.frame_kind;
    assign o_result.frame_number = r_frame.frame_number;
    assign o_result.voice_only   = (r_frame.frame_kind[2:1] == vsfp_pkg::VOICE_BITS);
    assign o_result.crc_match    = r_frame.crc_match;
    // first half goes out while two remain
    assign o_result.last_half    = (r_left == 2'd1);
    assign o_result.payload_half = o_result.last_half ? r_frame.payload1 : r_frame.payload0;

endmodule

FILE: design/vsfp_capture.sv
module vsfp_capture (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_data,
    input  logic                 i_end,
    input  logic [15:0]          i_poly,
    output vsfp_pkg::t_frame     o_frame,
    output vsfp_pkg::t_cap_status o_stat
);

    logic [vsfp_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [15:0] r_crc, n_crc, c_crc;
    logic [15:0] r_stream, n_stream;
    logic [47:0] r_dest, n_dest;
    logic [47:0] r_source, n_source;
    logic [15:0] r_kind, n_kind;
    logic [15:0] r_fnum, n_fnum;
    logic [63:0] r_pay0, n_pay0;
    logic [63:0] r_pay1, n_pay1;
    logic [15:0] r_rxcrc, n_rxcrc;
    logic        live;

    assign live = i_take && (r_idx < vsfp_pkg::FRAME_BYTES);

    always_comb begin
        c_crc    = r_crc;
        n_stream = r_stream;
        n_dest   = r_dest;
        n_source = r_source;
        n_kind   = r_kind;
        n_fnum   = r_fnum;
        n_pay0   = r_pay0;
        n_pay1   = r_pay1;
        n_rxcrc  = r_rxcrc;
        n_idx    = r_idx;
        if (live) begin
            n_idx = r_idx + 6'd1;
            if (r_idx < vsfp_pkg::CRC_BYTES) begin
                c_crc = vsfp_pkg::crc_byte(r_crc, i_data, i_poly);
            end
            if (r_idx < vsfp_pkg::OFS_STREAM) begin
                // sync / magic bytes: CRC only
            end else if (r_idx < vsfp_pkg::OFS_DEST) begin
                n_stream = {r_stream[7:0], i_data};
            end else if (r_idx < vsfp_pkg::OFS_SOURCE) begin
                n_dest = {r_dest[39:0], i_data};
            end else if (r_idx < vsfp_pkg::OFS_KIND) begin
                n_source = {r_source[39:0], i_data};
            end else if (r_idx < vsfp_pkg::OFS_KIND_END) begin
                n_kind = {r_kind[7:0], i_data};
            end else if (r_idx < vsfp_pkg::OFS_FNUM) begin
                // nonce: not kept
            end else if (r_idx < vsfp_pkg::OFS_PAYLOAD0) begin
                n_fnum = {r_fnum[7:0], i_data};
            end else if (r_idx < vsfp_pkg::OFS_PAYLOAD1) begin
                n_pay0 = {r_pay0[55:0], i_data};
            end else if (r_idx < vsfp_pkg::CRC_BYTES) begin
                n_pay1 = {r_pay1[55:0], i_data};
            end else begin
                n_rxcrc = {r_rxcrc[7:0], i_data};
            end
        end
        n_crc = c_crc;
        if (i_take && i_end) begin
            n_idx = '0;
            n_crc = vsfp_pkg::CRC_SEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= vsfp_pkg::CRC_SEED;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stream <= n_stream;
        r_dest   <= n_dest;
        r_source <= n_source;
        r_kind   <= n_kind;
        r_fnum   <= n_fnum;
        r_pay0   <= n_pay0;
        r_pay1   <= n_pay1;
        r_rxcrc  <= n_rxcrc;
    end

    // frame seen through the current byte
    assign o_frame.stream_id    = n_stream;
    assign o_frame.dest_code    = n_dest;
    assign o_frame.source_code  = n_source;
    assign o_frame.frame_kind   = n_kind;
    assign o_frame.frame_number = n_fnum;
    assign o_frame.crc_match    = (c_crc == n_rxcrc);
    assign o_frame.payload0     = n_pay0;
    assign o_frame.payload1     = n_pay1;

    assign o_stat.near_end   = (r_idx >= vsfp_pkg::LAST_BYTE);
    assign o_stat.frame_done = i_take && i_end && (r_idx >= vsfp_pkg::LAST_BYTE);

endmodule

FILE: design/vsfp_checker.sv
module vsfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [15:0] i_stream_id,
    input logic [15:0] i_frame_kind,
    input logic        i_voice_only,
    input logic        i_crc_match,
    input logic [63:0] i_payload_half,
    input logic        i_last_half
);

    // first half is always followed by the second half of the same frame
    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last_half |=> i_valid && i_last_half)
        else $error("second half missing after first half");

    a_same_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last_half |=> $stable(i_stream_id) && $stable(i_crc_match)
                                               && $stable(i_frame_kind))
        else $error("halves of one frame disagree on header");

    a_voice_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_voice_only == (i_frame_kind[2:1] == vsfp_pkg::VOICE_BITS)))
        else $error("voice flag inconsistent with frame kind");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_payload_half) && $stable(i_last_half))
        else $error("stalled result changed");

endmodule

bind voice_stream_frame_parser_unit vsfp_checker u_vsfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_result.valid),
    .i_ready        (o_result.ready),
    .i_stream_id    (o_result.stream_id),
    .i_frame_kind   (o_result.frame_kind),
    .i_voice_only   (o_result.voice_only),
    .i_crc_match    (o_result.crc_match),
    .i_payload_half (o_result.payload_half),
    .i_last_half    (o_result.last_half)
);
